/* rtl/core/dfs_pkg.sv */
// Package: shared constants, item structs, memory request structs and FSM states.
package dfs_pkg;

    localparam int N       = 64;
    localparam int VTX_W   = 7;
    localparam int VIDX_W  = $clog2(N);
    localparam int DEP_W   = $clog2(N + 1);
    localparam int CIDX_W  = 1;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_START  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_TARGET = 1'b1;

    typedef struct packed {
        logic [1:0]       action;
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             found;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic [VIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [VIDX_W-1:0] wr_addr;
        logic [N-1:0]      wr_row;
        logic              clear;
    } t_adj_req;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [VIDX_W-1:0] addr;
        logic [VTX_W-1:0]  wr_data;
    } t_stk_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_CHECK,
        ST_SCAN,
        ST_POP_WAIT,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_NOPATH
    } t_state;

endpackage

/* rtl/core/dfs_adj_store.sv */
// Adjacency matrix memory: one row per vertex, per-row valid bits, registered read.
module dfs_adj_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dfs_pkg::t_adj_req       i_req,
    output logic [dfs_pkg::N-1:0]   o_rd_row
);
    import dfs_pkg::*;

    logic [N-1:0] mem [N];
    logic [N-1:0] r_row_vld;
    logic [N-1:0] r_rd_data;
    logic         r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_row;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // row valid bits: a row never written since reset or clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_row_vld <= '0;
            end else if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_data & {N{r_rd_vld}};

endmodule

/* rtl/core/dfs_path_stack.sv */
// Path stack memory: single port, registered read.
module dfs_path_stack (
    input  logic                      i_clk,
    input  dfs_pkg::t_stk_req         i_req,
    output logic [dfs_pkg::VTX_W-1:0] o_rd_data
);
    import dfs_pkg::*;

    logic [VTX_W-1:0] mem [N];
    logic [VTX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/dfs_search_ctrl.sv */
// Sequencer: edge insert, graph clear, DFS walk over the memories and path readout.
module dfs_search_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  dfs_pkg::t_in_item         i_cmd,
    output logic                      o_cmd_ready,
    input  logic [dfs_pkg::VTX_W-1:0] i_start,
    input  logic [dfs_pkg::VTX_W-1:0] i_target,
    input  logic                      i_out_free,
    output logic                      o_out_load,
    output dfs_pkg::t_out_item        o_out_word,
    output dfs_pkg::t_adj_req         o_adj_req,
    input  logic [dfs_pkg::N-1:0]     i_adj_row,
    output dfs_pkg::t_stk_req         o_stk_req,
    input  logic [dfs_pkg::VTX_W-1:0] i_stk_data
);
    import dfs_pkg::*;

    function automatic logic f_vtx_ok(input logic [VTX_W-1:0] v);
        return (v != '0) && (v <= VTX_W'(N));
    endfunction

    function automatic logic [VIDX_W-1:0] f_bit_index(input logic [N-1:0] onehot);
        logic [VIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (onehot[i]) begin
                idx = idx | VIDX_W'(i);
            end
        end
        return idx;
    endfunction

    t_state            r_state, n_state;
    logic [VIDX_W-1:0] r_a, n_a;
    logic [VIDX_W-1:0] r_b, n_b;
    logic [N-1:0]      r_visited, n_visited;
    logic [DEP_W-1:0]  r_depth, n_depth;
    logic [DEP_W-1:0]  r_k, n_k;
    logic [VTX_W-1:0]  r_top, n_top;

    logic [N-1:0]      cand;
    logic [N-1:0]      iso;
    logic [VIDX_W-1:0] low_idx;
    logic [VIDX_W-1:0] start_idx;
    logic [VIDX_W-1:0] top_idx;
    logic              emit_last;

    assign cand      = i_adj_row & ~r_visited;
    assign iso       = cand & (~cand + N'(1));
    assign low_idx   = f_bit_index(iso);
    assign start_idx = VIDX_W'(i_start - VTX_W'(1));
    assign top_idx   = VIDX_W'(r_top - VTX_W'(1));
    assign emit_last = (r_k == (r_depth - DEP_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_visited <= '0;
            r_depth   <= '0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_top <= n_top;
    end

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_k         = r_k;
        n_top       = r_top;
        o_cmd_ready = 1'b0;
        o_out_load  = 1'b0;
        o_out_word  = '0;
        o_adj_req   = '0;
        o_stk_req   = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    priority case (i_cmd.action)
                        ACT_ADD: begin
                            if (f_vtx_ok(i_cmd.end_a) && f_vtx_ok(i_cmd.end_b)) begin
                                n_a     = VIDX_W'(i_cmd.end_a - VTX_W'(1));
                                n_b     = VIDX_W'(i_cmd.end_b - VTX_W'(1));
                                n_state = ST_ADD_RD_A;
                            end
                        end
                        ACT_RUN: begin
                            n_visited = '0;
                            n_depth   = '0;
                            if (!f_vtx_ok(i_start) || !f_vtx_ok(i_target)) begin
                                n_state = ST_NOPATH;
                            end else begin
                                n_visited[start_idx] = 1'b1;
                                o_stk_req.wr_en      = 1'b1;
                                o_stk_req.addr       = '0;
                                o_stk_req.wr_data    = i_start;
                                n_depth              = DEP_W'(1);
                                n_top                = i_start;
                                n_state              = ST_CHECK;
                            end
                        end
                        ACT_CLEAR: begin
                            o_adj_req.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_RD_A: begin
                o_adj_req.rd_en   = 1'b1;
                o_adj_req.rd_addr = r_a;
                n_state           = ST_ADD_WR_A;
            end
            ST_ADD_WR_A: begin
                o_adj_req.wr_en         = 1'b1;
                o_adj_req.wr_addr       = r_a;
                o_adj_req.wr_row        = i_adj_row;
                o_adj_req.wr_row[r_b]   = 1'b1;
                n_state                 = ST_ADD_RD_B;
            end
            ST_ADD_RD_B: begin
                o_adj_req.rd_en   = 1'b1;
                o_adj_req.rd_addr = r_b;
                n_state           = ST_ADD_WR_B;
            end
            ST_ADD_WR_B: begin
                o_adj_req.wr_en         = 1'b1;
                o_adj_req.wr_addr       = r_b;
                o_adj_req.wr_row        = i_adj_row;
                o_adj_req.wr_row[r_a]   = 1'b1;
                n_state                 = ST_IDLE;
            end
            ST_CHECK: begin
                if (r_top == i_target) begin
                    n_k     = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    o_adj_req.rd_en   = 1'b1;
                    o_adj_req.rd_addr = top_idx;
                    n_state           = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cand == '0) begin
                    // dead end: pop and fetch the new top
                    n_depth = r_depth - DEP_W'(1);
                    if (r_depth == DEP_W'(1)) begin
                        n_state = ST_NOPATH;
                    end else begin
                        o_stk_req.rd_en = 1'b1;
                        o_stk_req.addr  = VIDX_W'(r_depth - DEP_W'(2));
                        n_state         = ST_POP_WAIT;
                    end
                end else begin
                    n_visited         = r_visited | iso;
                    o_stk_req.wr_en   = 1'b1;
                    o_stk_req.addr    = VIDX_W'(r_depth);
                    o_stk_req.wr_data = VTX_W'(low_idx) + VTX_W'(1);
                    n_depth           = r_depth + DEP_W'(1);
                    n_top             = VTX_W'(low_idx) + VTX_W'(1);
                    n_state           = ST_CHECK;
                end
            end
            ST_POP_WAIT: begin
                n_top   = i_stk_data;
                n_state = ST_CHECK;
            end
            ST_EMIT_RD: begin
                o_stk_req.rd_en = 1'b1;
                o_stk_req.addr  = VIDX_W'(r_k);
                n_state         = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_out_free) begin
                    o_out_load        = 1'b1;
                    o_out_word.vertex = i_stk_data;
                    o_out_word.found  = 1'b1;
                    o_out_word.last   = emit_last;
                    n_k               = r_k + DEP_W'(1);
                    n_state           = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_NOPATH: begin
                if (i_out_free) begin
                    o_out_load        = 1'b1;
                    o_out_word.vertex = '0;
                    o_out_word.found  = 1'b0;
                    o_out_word.last   = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dfs_path_finder_top.sv */
// Top level of the DFS path finder: config registers, output register, memories, sequencer.
// Sequence: an add edge reads and rewrites the row of each end in turn; a clear acts in idle; a run
//   walks and backtracks, then reads the path out word by word or sends one no-path word.
// Throughput: one input word at a time, taken once the sequencer is back in idle. Output stalls
//   hold the path readout.
// Reset: synchronous, active low; graph empty (row valid bits cleared), start and target = 1,
//   output empty. The path stack holds no reset value and is only read where written.
module dfs_path_finder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command words
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dfs_pkg::t_in_item          i_in_data,
    // path words
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dfs_pkg::t_out_item         o_out_data,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dfs_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [dfs_pkg::VTX_W-1:0]  i_cfg_data
);
    import dfs_pkg::*;

    // configuration registers; the user must write them only while idle, which the block has no check for
    logic [VTX_W-1:0] r_start;
    logic [VTX_W-1:0] r_target;

    // output register: parts the sequencer from the consumer
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             out_free;
    logic             out_load;
    t_out_item        out_word;
    t_adj_req         adj_req;
    logic [N-1:0]     adj_row;
    t_stk_req         stk_req;
    logic [VTX_W-1:0] stk_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= VTX_W'(1);
            r_target <= VTX_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START:  r_start  <= i_cfg_data;
                CFG_TARGET: r_target <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // free when empty or when the waiting word leaves this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    dfs_adj_store u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (adj_req),
        .o_rd_row (adj_row)
    );

    dfs_path_stack u_stk (
        .i_clk     (i_clk),
        .i_req     (stk_req),
        .o_rd_data (stk_data)
    );

    dfs_search_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .i_cmd       (i_in_data),
        .o_cmd_ready (o_in_ready),
        .i_start     (r_start),
        .i_target    (r_target),
        .i_out_free  (out_free),
        .o_out_load  (out_load),
        .o_out_word  (out_word),
        .o_adj_req   (adj_req),
        .i_adj_row   (adj_row),
        .o_stk_req   (stk_req),
        .i_stk_data  (stk_data)
    );

endmodule

/* sim/dfs_path_checker.sv */
// Checker for the DFS path finder: predicts path words from the command and config channels.
module dfs_path_checker
    import dfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [VTX_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic [N-1:0]     adj_row [N];
    logic [VTX_W-1:0] start_reg;
    logic [VTX_W-1:0] target_reg;
    t_out_item        path_q [$];
    int               fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic bit vertex_valid(logic [VTX_W-1:0] v);
        return (v >= 1) && (v <= N);
    endfunction

    function automatic void queue_word(logic [VTX_W-1:0] v, logic f, logic l);
        t_out_item word;
        word.vertex = v;
        word.found  = f;
        word.last   = l;
        path_q = {path_q, word};
    endfunction

    // lowest-index-first DFS on an explicit stack; fresh visited set per run
    function automatic void predict_path();
        logic [N-1:0]     seen;
        logic [N-1:0]     open_set;
        logic [VTX_W-1:0] stack [N];
        logic [VTX_W-1:0] top_v;
        int               depth;
        int               pick;
        if (!vertex_valid(start_reg) || !vertex_valid(target_reg)) begin
            queue_word('0, 1'b0, 1'b1);
            return;
        end
        seen = '0;
        seen[start_reg - 1] = 1'b1;
        stack[0] = start_reg;
        depth = 1;
        while (depth > 0) begin
            top_v = stack[depth - 1];
            if (top_v == target_reg)
                break;
            open_set = adj_row[top_v - 1] & ~seen;
            if (open_set == '0) begin
                depth--;
            end else begin
                pick = 0;
                while (!open_set[pick])
                    pick++;
                seen[pick] = 1'b1;
                stack[depth] = VTX_W'(pick + 1);
                depth++;
            end
        end
        if (depth == 0) begin
            queue_word('0, 1'b0, 1'b1);
            return;
        end
        for (int k = 0; k < depth; k++)
            queue_word(stack[k], 1'b1, k == depth - 1);
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            for (int r = 0; r < N; r++)
                adj_row[r] = '0;
            start_reg  = 7'd1;
            target_reg = 7'd1;
            path_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START)
                    start_reg = i_cfg_data;
                else if (i_cfg_index == CFG_TARGET)
                    target_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (path_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("mismatch at %0t: unexpected word vertex %0d found %0b last %0b",
                                 $time, i_out_data.vertex, i_out_data.found, i_out_data.last);
                    fail_cnt++;
                end else begin
                    want = path_q.pop_front();
                    if (want.vertex !== i_out_data.vertex || want.found !== i_out_data.found ||
                            want.last !== i_out_data.last) begin
                        if (fail_cnt < 10) begin
                            $display("mismatch at %0t: want vertex %0d found %0b last %0b",
                                     $time, want.vertex, want.found, want.last);
                            $display("    got vertex %0d found %0b last %0b",
                                     i_out_data.vertex, i_out_data.found, i_out_data.last);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.action)
                    ACT_ADD: begin
                        if (vertex_valid(i_in_data.end_a) && vertex_valid(i_in_data.end_b)) begin
                            adj_row[i_in_data.end_a - 1][i_in_data.end_b - 1] = 1'b1;
                            adj_row[i_in_data.end_b - 1][i_in_data.end_a - 1] = 1'b1;
                        end
                    end
                    ACT_RUN: predict_path();
                    ACT_CLEAR: begin
                        for (int r = 0; r < N; r++)
                            adj_row[r] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= path_q.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top: clock, reset, command/config stimulus and verdict for the DFS path finder.
module tb_top;
    import dfs_pkg::*;

    // action code the block must ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = CFG_START;
    logic [VTX_W-1:0]  cfg_data  = '0;
    int                fail_count;
    int                pending;

    // set during a run of phases where neither side idles
    logic              steady    = 1'b0;
    // command words that do real work (ignored ones are not counted)
    int                words_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dfs_path_finder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dfs_path_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver side: drop ready about a quarter of the time, never while steady.
    always @(posedge clk) begin
        if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 25);
    end

    // Present one command word and hold it until accepted. On return we sit at the
    // accepting edge with valid still high; the caller either sends the next word
    // (one assignment to valid in this step) or drains, which lowers valid.
    task automatic send_word(input logic [1:0] act, input logic [VTX_W-1:0] a,
                             input logic [VTX_W-1:0] b);
        t_in_item word;
        int       gap;
        word.action = act;
        word.end_a  = a;
        word.end_b  = b;
        if (!steady && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= word;
        do @(posedge clk); while (!in_ready);
        if (act == ACT_RUN || act == ACT_CLEAR ||
                (act == ACT_ADD && a >= 1 && a <= N && b >= 1 && b <= N))
            words_sent++;
    endtask

    // Stop sending and wait for every predicted path word to come out. The pending
    // count read at an edge reflects words queued at the edge before, so the first
    // look already covers a run word accepted just now.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Config words go in only with the block idle. An add or clear leaves no result
    // to wait on, so give it the add-edge latency plus margin before writing.
    task automatic write_regs(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] t);
        drain_results();
        repeat (16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START;
        cfg_data  <= s;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_TARGET;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random add word: mostly in-range edges among 1..hi, some noise endpoints drawn
    // from 0..127 (so 0 and above the vertex count can come up) and the odd unknown action.
    task automatic random_edge(input int hi);
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        int               roll;
        roll = $urandom_range(0, 99);
        a = VTX_W'($urandom_range(1, hi));
        b = VTX_W'($urandom_range(1, hi));
        if (roll < 5)
            send_word(ACT_NONE, VTX_W'($urandom_range(0, 127)), VTX_W'($urandom_range(0, 127)));
        else if (roll < 14)
            send_word(ACT_ADD, VTX_W'($urandom_range(0, 127)), VTX_W'($urandom_range(0, 127)));
        else
            send_word(ACT_ADD, a, b);
    endtask

    initial begin : stimulus
        logic [VTX_W-1:0] order [N];
        logic [VTX_W-1:0] s;
        logic [VTX_W-1:0] t;
        logic [VTX_W-1:0] swap;
        int               hi;
        int               phase;
        int               n_edges;
        int               n_runs;
        int               j;
        bit               chain;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // start and target both reset to 1: a one-word path
        send_word(ACT_RUN, '0, '0);
        // 1-2, 2-3 (dead end), 64-10, 10-2, 1-4: search 1->64 has to back out of 3
        send_word(ACT_ADD, 7'd1, 7'd2);
        send_word(ACT_ADD, 7'd2, 7'd3);
        send_word(ACT_ADD, 7'd64, 7'd10);
        send_word(ACT_ADD, 7'd10, 7'd2);
        send_word(ACT_ADD, 7'd1, 7'd4);
        send_word(ACT_ADD, 7'd2, 7'd1);     // duplicate, reversed
        send_word(ACT_ADD, 7'd5, 7'd5);     // self loop
        send_word(ACT_ADD, 7'd0, 7'd3);     // endpoint zero, ignored
        send_word(ACT_ADD, 7'd3, 7'd127);   // endpoint past the last vertex, ignored
        send_word(ACT_ADD, 7'd65, 7'd1);    // same
        send_word(ACT_NONE, 7'd7, 7'd8);    // unknown action, ignored
        write_regs(7'd1, 7'd64);
        send_word(ACT_RUN, '0, '0);
        write_regs(7'd64, 7'd1);
        send_word(ACT_RUN, '0, '0);
        write_regs(7'd5, 7'd1);             // only a self loop: no path
        send_word(ACT_RUN, '0, '0);
        write_regs(7'd0, 7'd64);            // start out of range
        send_word(ACT_RUN, '0, '0);
        write_regs(7'd3, 7'd127);           // target out of range
        send_word(ACT_RUN, '0, '0);
        write_regs(7'd64, 7'd64);           // start equals target
        send_word(ACT_RUN, '0, '0);
        send_word(ACT_CLEAR, '0, '0);
        write_regs(7'd1, 7'd64);            // graph cleared: no path
        send_word(ACT_RUN, '0, '0);

        // ---- random part ----
        // Each phase picks a vertex span, writes start/target, builds a graph and
        // runs several searches with more edges added between them. Some phases lay
        // a random Hamiltonian chain from start to target through the whole span.
        phase = 0;
        while (words_sent < 280) begin
            phase++;
            steady <= (phase >= 4 && phase < 8);
            case ($urandom_range(0, 3))
                0: hi = 4;
                1: hi = 8;
                2: hi = 16;
                default: hi = N;
            endcase
            chain = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < hi; i++)
                order[i] = VTX_W'(i + 1);
            for (int i = hi - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                swap = order[i];
                order[i] = order[j];
                order[j] = swap;
            end
            if (chain) begin
                s = order[0];
                t = order[hi - 1];
            end else begin
                s = VTX_W'($urandom_range(1, hi));
                t = VTX_W'($urandom_range(1, hi));
            end
            // now and then an out-of-range register value
            case ($urandom_range(0, 19))
                0: s = '0;
                1: s = VTX_W'($urandom_range(N + 1, 127));
                2: t = '0;
                3: t = VTX_W'($urandom_range(N + 1, 127));
                default: ;
            endcase
            write_regs(s, t);

            if ($urandom_range(0, 1) == 1)
                send_word(ACT_CLEAR, VTX_W'($urandom_range(0, 127)),
                          VTX_W'($urandom_range(0, 127)));
            if (chain) begin
                for (int i = 0; i < hi - 1; i++) begin
                    if ($urandom_range(0, 1) == 1)
                        send_word(ACT_ADD, order[i], order[i + 1]);
                    else
                        send_word(ACT_ADD, order[i + 1], order[i]);
                end
                n_edges = $urandom_range(0, 3);
            end else if (hi == N) begin
                n_edges = $urandom_range(30, 80);
            end else begin
                n_edges = $urandom_range(2, 2 * hi);
            end
            repeat (n_edges) random_edge(hi);

            n_runs = $urandom_range(2, 4);
            repeat (n_runs) begin
                send_word(ACT_RUN, VTX_W'($urandom_range(0, 127)), VTX_W'($urandom_range(0, 127)));
                repeat ($urandom_range(0, 3)) random_edge(hi);
            end
        end
        steady <= 1'b0;

        // everything sent: wait out the last results, then a run's worth of cycles
        drain_results();
        repeat (500) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #30000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dfs_pkg.sv
rtl/core/dfs_adj_store.sv
rtl/core/dfs_path_stack.sv
rtl/core/dfs_search_ctrl.sv
rtl/core/dfs_path_finder_top.sv
sim/dfs_path_checker.sv
sim/tb_top.sv
